/* rtl/core/mpd_pkg.sv */
// Shared types, constants and the letter lookup for the Morse press decoder.
package mpd_pkg;

  localparam int MaxSymbols = 4;
  localparam int CountW     = 3;
  localparam int DurW       = 16;
  localparam int LetterW    = 5;
  localparam int StatusW    = 2;
  localparam int CfgIndexW  = 1;

  localparam logic [DurW-1:0] DotLimitReset  = 16'd200;
  localparam logic [DurW-1:0] DashLimitReset = 16'd700;

  // Input kinds.
  localparam logic KindPress = 1'b0;
  localparam logic KindGap   = 1'b1;

  // Result status codes.
  localparam logic [StatusW-1:0] StatusLetter  = 2'd0;
  localparam logic [StatusW-1:0] StatusNoMatch = 2'd1;
  localparam logic [StatusW-1:0] StatusTooLong = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] RegDotLimit  = 1'b0;
  localparam logic [CfgIndexW-1:0] RegDashLimit = 1'b1;

  typedef struct packed {
    logic            kind;
    logic [DurW-1:0] press_ms;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [LetterW-1:0] letter;
  } out_item_t;

  // What one item does to the symbol buffer and whether it yields a result.
  typedef struct packed {
    logic                  has_result;
    out_item_t             result;
    logic [MaxSymbols-1:0] symbols_next;
    logic [CountW-1:0]     count_next;
  } step_t;

  typedef struct packed {
    logic               found;
    logic [LetterW-1:0] letter;
  } lookup_t;

  // Match a buffered symbol pattern against the 26 letters.
  // Bit i of the pattern is symbol i, a set bit is a dash; unused bits are zero.
  function automatic lookup_t letter_lookup(input logic [CountW-1:0] count,
                                            input logic [MaxSymbols-1:0] bits);
    lookup_t r;
    r.found  = 1'b1;
    r.letter = '0;
    case ({count, bits})
      {3'd1, 4'd0}:  r.letter = 5'd4;
      {3'd1, 4'd1}:  r.letter = 5'd19;
      {3'd2, 4'd2}:  r.letter = 5'd0;
      {3'd2, 4'd0}:  r.letter = 5'd8;
      {3'd2, 4'd3}:  r.letter = 5'd12;
      {3'd2, 4'd1}:  r.letter = 5'd13;
      {3'd3, 4'd1}:  r.letter = 5'd3;
      {3'd3, 4'd3}:  r.letter = 5'd6;
      {3'd3, 4'd5}:  r.letter = 5'd10;
      {3'd3, 4'd7}:  r.letter = 5'd14;
      {3'd3, 4'd2}:  r.letter = 5'd17;
      {3'd3, 4'd0}:  r.letter = 5'd18;
      {3'd3, 4'd4}:  r.letter = 5'd20;
      {3'd3, 4'd6}:  r.letter = 5'd22;
      {3'd4, 4'd1}:  r.letter = 5'd1;
      {3'd4, 4'd5}:  r.letter = 5'd2;
      {3'd4, 4'd4}:  r.letter = 5'd5;
      {3'd4, 4'd0}:  r.letter = 5'd7;
      {3'd4, 4'd14}: r.letter = 5'd9;
      {3'd4, 4'd2}:  r.letter = 5'd11;
      {3'd4, 4'd6}:  r.letter = 5'd15;
      {3'd4, 4'd11}: r.letter = 5'd16;
      {3'd4, 4'd8}:  r.letter = 5'd21;
      {3'd4, 4'd9}:  r.letter = 5'd23;
      {3'd4, 4'd13}: r.letter = 5'd24;
      {3'd4, 4'd3}:  r.letter = 5'd25;
      default:       r.found  = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/mpd_step.sv */
// Combinational classification, buffer append and letter decode for one item.
module mpd_step (
  input  mpd_pkg::in_item_t                      item,
  input  logic [mpd_pkg::DurW-1:0]               dot_limit,
  input  logic [mpd_pkg::DurW-1:0]               dash_limit,
  input  logic [mpd_pkg::MaxSymbols-1:0]         symbols,
  input  logic [mpd_pkg::CountW-1:0]             count,
  output mpd_pkg::step_t                         step
);
  import mpd_pkg::*;

  logic                  is_dot;
  logic                  is_dash;
  logic                  too_long;
  logic [MaxSymbols-1:0] app_symbols;
  logic [CountW-1:0]     app_count;
  logic [MaxSymbols-1:0] dec_symbols;
  logic [CountW-1:0]     dec_count;
  lookup_t               hit;

  // Press classification, tested in order so a press at a limit falls through.
  assign is_dot   = (item.press_ms != '0) && (item.press_ms < dot_limit);
  assign is_dash  = !is_dot && (item.press_ms > dot_limit)
                    && (item.press_ms < dash_limit);
  assign too_long = !is_dot && !is_dash && (item.press_ms > dash_limit);

  // Buffer after appending this press; the buffer never rests full.
  always_comb begin
    app_symbols = symbols;
    app_symbols[count[1:0]] = is_dash;
    app_count = count + CountW'(1);
  end

  // The pattern to decode: the buffer as it stands for a gap, or the appended one.
  assign dec_symbols = (item.kind == KindGap) ? symbols : app_symbols;
  assign dec_count   = (item.kind == KindGap) ? count : app_count;
  assign hit         = letter_lookup(dec_count, dec_symbols);

  always_comb begin
    step.has_result    = 1'b0;
    step.result.status = StatusLetter;
    step.result.letter = '0;
    step.symbols_next  = symbols;
    step.count_next    = count;
    if (item.kind == KindGap) begin
      // A gap decodes a non-empty buffer and always clears it.
      if (count != '0) begin
        step.symbols_next = '0;
        step.count_next   = '0;
        if (hit.found) begin
          step.has_result    = 1'b1;
          step.result.letter = hit.letter;
        end else if (count >= CountW'(MaxSymbols)) begin
          step.has_result    = 1'b1;
          step.result.status = StatusNoMatch;
        end
      end
    end else if (is_dot || is_dash) begin
      if (app_count >= CountW'(MaxSymbols)) begin
        // Full buffer decodes at once.
        step.symbols_next = '0;
        step.count_next   = '0;
        step.has_result   = 1'b1;
        if (hit.found) begin
          step.result.letter = hit.letter;
        end else begin
          step.result.status = StatusNoMatch;
        end
      end else begin
        step.symbols_next = app_symbols;
        step.count_next   = app_count;
      end
    end else if (too_long) begin
      step.has_result    = 1'b1;
      step.result.status = StatusTooLong;
    end
  end

endmodule

/* rtl/core/morse_press_decoder_top.sv */
// Top level of the Morse press decoder: input stage, symbol buffer and result register.
// Decodes button-press Morse into letters: each beat is a press with its length in ms or a
// gap event that ends a letter. While in_stall is low, one beat is accepted per cycle with
// no bubbles; a beat waits in the input register, where the classify-and-decode logic
// updates the symbol buffer, and any result is loaded into the output register when the
// beat retires, which raises out_valid. in_stall rises only while out_stall holds a
// waiting result and the beat in the input register has a result of its own. The limits
// (index 0 dot_limit, index 1 dash_limit) reset to 200 and 700; the user must write them
// only while the block is idle (not enforced by the block); cfg_ready is always high.
module morse_press_decoder_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mpd_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mpd_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mpd_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [mpd_pkg::DurW-1:0]        cfg_data
);
  import mpd_pkg::*;

  logic [DurW-1:0]       dot_limit;
  logic [DurW-1:0]       dash_limit;
  logic [MaxSymbols-1:0] symbols;
  logic [CountW-1:0]     count;
  logic                  s1_valid;
  in_item_t              s1_item;
  step_t                 step;
  logic                  s1_retire;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_limit  <= DotLimitReset;
      dash_limit <= DashLimitReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegDotLimit:  dot_limit  <= cfg_data;
        RegDashLimit: dash_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  mpd_step u_step (
    .item       (s1_item),
    .dot_limit  (dot_limit),
    .dash_limit (dash_limit),
    .symbols    (symbols),
    .count      (count),
    .step       (step)
  );

  // The staged beat retires unless its result would land on a held one.
  assign s1_retire = s1_valid && (!step.has_result || !out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_retire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item <= in_data;
    end
  end

  // Symbol buffer advances as each beat retires.
  always_ff @(posedge clk) begin
    if (rst) begin
      symbols <= '0;
      count   <= '0;
    end else if (s1_retire) begin
      symbols <= step.symbols_next;
      count   <= step.count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_retire && step.has_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_retire && step.has_result) begin
      out_data <= step.result;
    end
  end

endmodule

/* rtl/core/mpd_checker.sv */
// Port-level checks for the Morse press decoder, bound to the top level.
module mpd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input mpd_pkg::out_item_t              out_data
);
  import mpd_pkg::*;

  // A held result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Back-pressure on the input only comes from a stalled output.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // Errors carry letter zero, and letters stay within the alphabet.
  a_letter_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == StatusLetter && out_data.letter <= LetterW'(25))
               || ((out_data.status == StatusNoMatch || out_data.status == StatusTooLong)
                   && out_data.letter == '0))
    else $error("bad result payload");

  // No result shows in the first cycle after reset.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result right after reset");

endmodule

bind morse_press_decoder_top mpd_checker u_mpd_checker (.*);

/* tb/morse_press_decoder_top_tb.sv */
// Self-checking testbench for the Morse press decoder: directed and random press streams.
`timescale 1ns / 1ps

module morse_press_decoder_top_tb;
  import mpd_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned PrintCap    = 30;

  // Tracks the symbol buffer and limits, and holds the letters and errors still awaited.
  class letter_tracker;
    logic [DurW-1:0]       dot_lim;
    logic [DurW-1:0]       dash_lim;
    logic [MaxSymbols-1:0] sym_bits;
    int unsigned           sym_count;
    out_item_t             pending_decodes[$];
    int unsigned           mismatches;
    string                 morse_codes[26];

    function new();
      morse_codes = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
                      "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
                      "..-", "...-", ".--", "-..-", "-.--", "--.."};
      dot_lim     = DotLimitReset;
      dash_lim    = DashLimitReset;
      sym_bits    = '0;
      sym_count   = 0;
      mismatches  = 0;
    endfunction

    function void set_limit(logic [CfgIndexW-1:0] idx, logic [DurW-1:0] value);
      case (idx)
        RegDotLimit:  dot_lim = value;
        RegDashLimit: dash_lim = value;
        default: ;
      endcase
    endfunction

    // Look the buffer up in the letter list, queue the outcome and empty the buffer.
    function void decode_letter();
      logic [MaxSymbols-1:0] pattern;
      out_item_t             r;
      bit                    hit;
      hit      = 1'b0;
      r.status = StatusLetter;
      r.letter = '0;
      for (int i = 0; i < 26; i++) begin
        if (!hit && morse_codes[i].len() == sym_count) begin
          pattern = '0;
          for (int j = 0; j < morse_codes[i].len(); j++) begin
            pattern[2'(j)] = (morse_codes[i][j] == "-");
          end
          if (pattern == sym_bits) begin
            hit      = 1'b1;
            r.letter = LetterW'(i);
          end
        end
      end
      if (hit) begin
        pending_decodes.push_back(r);
      end else if (sym_count >= MaxSymbols) begin
        r.status = StatusNoMatch;
        pending_decodes.push_back(r);
      end
      sym_bits  = '0;
      sym_count = 0;
    endfunction

    // Apply one accepted input beat to the buffer.
    function void note_beat(in_item_t b);
      out_item_t r;
      logic [DurW-1:0] d;
      d = b.press_ms;
      if (b.kind == KindGap) begin
        if (sym_count != 0) decode_letter();
        return;
      end
      if (d != 0 && d < dot_lim) begin
        sym_bits[2'(sym_count)] = 1'b0;
        sym_count++;
      end else if (d > dot_lim && d < dash_lim) begin
        sym_bits[2'(sym_count)] = 1'b1;
        sym_count++;
      end else if (d > dash_lim) begin
        // A too-long press is reported without touching the buffer.
        r.status = StatusTooLong;
        r.letter = '0;
        pending_decodes.push_back(r);
        return;
      end else begin
        return;
      end
      if (sym_count >= MaxSymbols) decode_letter();
    endfunction

    task report_mismatch(string msg);
      if (mismatches < PrintCap) $display("tb: mismatch: %s", msg);
      mismatches++;
    endtask

    // Compare one accepted output beat with the oldest awaited outcome.
    task check_beat(out_item_t got);
      out_item_t want;
      if (pending_decodes.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d letter %0d",
                                  got.status, got.letter));
        return;
      end
      want = pending_decodes.pop_front();
      if (got.status !== want.status) begin
        report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
      end
      if (got.letter !== want.letter) begin
        report_mismatch($sformatf("letter %0d, wanted %0d", got.letter, want.letter));
      end
    endtask
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CfgIndexW-1:0]  cfg_index = RegDotLimit;
  logic [DurW-1:0]       cfg_data  = '0;

  letter_tracker tracker = new();

  int unsigned send_idle_pct   = 18;
  int unsigned recv_idle_pct   = 48;
  int unsigned hold_off_cycles = 0;
  int unsigned cycle_count     = 0;

  morse_press_decoder_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Run limit.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // Result side: check each accepted beat, then stall at random or for a long hold-off.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) tracker.check_beat(out_data);
      if (hold_off_cycles != 0) begin
        out_stall <= 1'b1;
        hold_off_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Offer one beat, with random idle cycles ahead of it, and wait until it is taken.
  task automatic send_beat(logic kind, logic [DurW-1:0] dur);
    in_item_t b;
    b.kind     = kind;
    b.press_ms = dur;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_beat(b);
  endtask

  // Press length chosen to land inside the dot or dash window, if that window is not empty.
  task automatic send_symbol(bit is_dash);
    logic [DurW-1:0] d;
    if (!is_dash && tracker.dot_lim > 1) begin
      d = DurW'($urandom_range(tracker.dot_lim - 1, 1));
    end else if (is_dash && tracker.dash_lim > tracker.dot_lim + 1) begin
      d = DurW'($urandom_range(tracker.dash_lim - 1, tracker.dot_lim + 1));
    end else begin
      d = DurW'($urandom);
    end
    send_beat(KindPress, d);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending_decodes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_limit(logic [CfgIndexW-1:0] idx, logic [DurW-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tracker.set_limit(idx, value);
  endtask

  // Mostly whole letters with random symbols, mixed with too-long, random and ignored presses.
  task automatic run_random(int unsigned n_items);
    int unsigned           counted;
    int unsigned           pick;
    int unsigned           len;
    logic [MaxSymbols-1:0] bits;
    counted = 0;
    while (counted < n_items) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        len  = $urandom_range(MaxSymbols, 1);
        bits = MaxSymbols'($urandom);
        for (int j = 0; j < len; j++) send_symbol(bits[j]);
        if (len < MaxSymbols || $urandom_range(3) == 0) begin
          send_beat(KindGap, DurW'($urandom));
          counted++;
        end
        counted += len;
      end else if (pick < 80) begin
        if (tracker.dash_lim < 16'hFFFF) begin
          send_beat(KindPress, DurW'($urandom_range(16'hFFFF, tracker.dash_lim + 1)));
        end
        counted++;
      end else if (pick < 90) begin
        send_beat(KindPress, DurW'($urandom));
        counted++;
      end else begin
        case ($urandom_range(3))
          0: send_beat(KindPress, '0);
          1: send_beat(KindPress, tracker.dot_lim);
          2: send_beat(KindPress, tracker.dash_lim);
          default: send_beat(KindGap, DurW'($urandom));
        endcase
        counted++;
      end
    end
  endtask

  // Main sequence.
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Ignored presses: zero length and exactly at each limit; gap on an empty buffer.
    send_beat(KindPress, 16'd0);
    send_beat(KindPress, 16'd200);
    send_beat(KindPress, 16'd700);
    send_beat(KindGap, 16'hFFFF);
    // Two dots, too-long presses in the middle leave the buffer alone, then a gap.
    send_beat(KindPress, 16'd1);
    send_beat(KindPress, 16'd199);
    send_beat(KindPress, 16'd701);
    send_beat(KindPress, 16'hFFFF);
    send_beat(KindGap, 16'd0);
    // Two dashes at the edges of the dash window.
    send_beat(KindPress, 16'd201);
    send_beat(KindPress, 16'd699);
    send_beat(KindGap, 16'h5A5A);
    // Full buffer with no letter, then a full buffer that is a letter.
    repeat (4) send_beat(KindPress, 16'd500);
    send_beat(KindPress, 16'd500);
    repeat (3) send_beat(KindPress, 16'd100);
    // Three dots, then a single dot, each closed by a gap.
    repeat (3) send_beat(KindPress, 16'd50);
    send_beat(KindGap, 16'hA5A5);
    send_beat(KindPress, 16'd150);
    send_beat(KindGap, 16'd1);
    run_random(150);

    // Only dashes are possible.
    write_limit(RegDotLimit, 16'd1);
    write_limit(RegDashLimit, 16'hFFFF);
    run_random(60);

    send_idle_pct = 48;
    recv_idle_pct = 18;
    // Only dots are possible, and nothing is too long.
    write_limit(RegDotLimit, 16'hFFFF);
    run_random(60);
    write_limit(RegDotLimit, DurW'($urandom_range(1000, 2)));
    write_limit(RegDashLimit, DurW'(tracker.dot_lim + $urandom_range(1500, 2)));
    run_random(150);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Dot limit above dash limit: the dash window is empty.
    write_limit(RegDotLimit, 16'hFFFF);
    write_limit(RegDashLimit, 16'd1);
    run_random(60);
    // Nearly every press is too long; the result side holds off until the input backs up.
    write_limit(RegDotLimit, 16'd1);
    hold_off_cycles = 150;
    run_random(60);

    write_limit(RegDotLimit, DotLimitReset);
    write_limit(RegDashLimit, DashLimitReset);
    run_random(150);

    wait_drained();
    if (tracker.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
